// ----- src/b64se_pkg.sv -----
package b64se_pkg;

  localparam int unsigned RunMax  = 6;
  localparam int unsigned RunCntW = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDatW = 8;

  localparam logic [CfgIdxW-1:0] CfgLineMode     = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgGroupsPerLine = 1'b1;

  localparam logic         LineModeReset = 1'b1;
  localparam logic [7:0]   GroupsReset   = 8'd19;

  localparam logic [7:0] CharCr  = 8'd13;
  localparam logic [7:0] CharLf  = 8'd10;
  localparam logic [7:0] CharPad = 8'd61;

  typedef enum logic [2:0] {
    PhNone = 3'b001,
    PhOne  = 3'b010,
    PhTwo  = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
    logic       message_end;
  } out_t;

  typedef struct packed {
    logic [RunMax-1:0][7:0] chars;
    logic [RunCntW-1:0]     cnt;
    logic                   msg_end;
  } run_t;

  function automatic logic [7:0] b64_sym(input logic [5:0] v);
    logic [7:0] c;
    c = 8'd0;
    case (v) inside
      [6'd0:6'd25]:  c = 8'd65 + {2'b00, v};
      [6'd26:6'd51]: c = 8'd71 + {2'b00, v};
      [6'd52:6'd61]: c = {2'b00, v} - 8'd4;
      6'd62:         c = 8'd43;
      default:       c = 8'd47;
    endcase
    return c;
  endfunction

endpackage

// ----- src/b64se_encode.sv -----
module b64se_encode (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  b64se_pkg::in_t  in_data_i,
  input  logic            line_mode_i,
  input  logic [7:0]      groups_per_line_i,
  output b64se_pkg::run_t run_o
);

  b64se_pkg::phase_e phase_q, phase_d;
  logic [3:0]        carry_q, carry_d;
  logic [7:0]        lgc_q, lgc_d;

  always_comb begin
    logic [b64se_pkg::RunMax-1:0][7:0] ch;
    logic [b64se_pkg::RunCntW-1:0]     n;
    logic [7:0]                        b;
    b = in_data_i.data_byte;
    ch = '0;
    n = '0;
    phase_d = phase_q;
    carry_d = carry_q;
    lgc_d = lgc_q;

    if (in_data_i.has_byte) begin
      case (phase_q)
        b64se_pkg::PhOne: begin
          ch[n] = b64se_pkg::b64_sym({carry_q[1:0], b[7:4]});
          n = n + 3'd1;
          carry_d = b[3:0];
          phase_d = b64se_pkg::PhTwo;
        end
        b64se_pkg::PhTwo: begin
          ch[n] = b64se_pkg::b64_sym({carry_q, b[7:6]});
          n = n + 3'd1;
          ch[n] = b64se_pkg::b64_sym(b[5:0]);
          n = n + 3'd1;
          carry_d = 4'd0;
          phase_d = b64se_pkg::PhNone;
          lgc_d = lgc_q + 8'd1;
          if (lgc_d == groups_per_line_i) begin
            lgc_d = 8'd0;
            if (line_mode_i) begin
              ch[n] = b64se_pkg::CharCr;
              n = n + 3'd1;
              ch[n] = b64se_pkg::CharLf;
              n = n + 3'd1;
            end
          end
        end
        default: begin
          ch[n] = b64se_pkg::b64_sym(b[7:2]);
          n = n + 3'd1;
          carry_d = {2'b00, b[1:0]};
          phase_d = b64se_pkg::PhOne;
        end
      endcase
    end

    if (in_data_i.last) begin
      case (phase_d)
        b64se_pkg::PhOne: begin
          ch[n] = b64se_pkg::b64_sym({carry_d[1:0], 4'd0});
          n = n + 3'd1;
          ch[n] = b64se_pkg::CharPad;
          n = n + 3'd1;
          ch[n] = b64se_pkg::CharPad;
          n = n + 3'd1;
        end
        b64se_pkg::PhTwo: begin
          ch[n] = b64se_pkg::b64_sym({carry_d, 2'd0});
          n = n + 3'd1;
          ch[n] = b64se_pkg::CharPad;
          n = n + 3'd1;
        end
        default: ;
      endcase
      // closing break, even straight after a line break
      if (line_mode_i) begin
        ch[n] = b64se_pkg::CharCr;
        n = n + 3'd1;
        ch[n] = b64se_pkg::CharLf;
        n = n + 3'd1;
      end
      phase_d = b64se_pkg::PhNone;
      carry_d = 4'd0;
      lgc_d = 8'd0;
    end

    run_o.chars = ch;
    run_o.cnt = n;
    run_o.msg_end = in_data_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= b64se_pkg::PhNone;
      carry_q <= 4'd0;
      lgc_q <= 8'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
      lgc_q <= lgc_d;
    end
  end

endmodule

// ----- src/b64se_serial.sv -----
module b64se_serial (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  b64se_pkg::run_t run_i,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output b64se_pkg::out_t out_data_o,
  output logic            free_o
);

  logic [b64se_pkg::RunMax-1:0][7:0] chars_q;
  logic [b64se_pkg::RunCntW-1:0]     rem_q;
  logic                              end_q;
  logic                              pop;

  assign out_valid_o = (rem_q != '0);
  assign pop = out_valid_o && !out_stall_i;
  // take a new word once the run is empty or its final character leaves now
  assign free_o = (rem_q == '0) || ((rem_q == 3'd1) && pop);

  assign out_data_o.out_char = chars_q[0];
  assign out_data_o.last_of_run = (rem_q == 3'd1);
  assign out_data_o.message_end = (rem_q == 3'd1) && end_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      chars_q <= run_i.chars;
    end else if (pop) begin
      for (int i = 0; i < b64se_pkg::RunMax - 1; i++) begin
        chars_q[i] <= chars_q[i+1];
      end
      chars_q[b64se_pkg::RunMax-1] <= 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      end_q <= 1'b0;
    end else if (load_i) begin
      rem_q <= run_i.cnt;
      end_q <= run_i.msg_end;
    end else if (pop) begin
      rem_q <= rem_q - 3'd1;
    end
  end

endmodule

// ----- src/base64_stream_encoder_unit.sv -----
// Channel  | Direction | Handshake              | Payload
// input    | in        | in_valid_i / in_stall_o | in_data_i  (byte, has_byte, last)
// output   | out       | out_valid_o / out_stall_i | out_data_o (char, run end, msg end)
// config   | in        | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// One character leaves per cycle while the output is not stalled. An item yielding
// 1 to 6 characters is loaded as one run and stalls the input until its final
// character leaves; one yielding none loads nothing, so runs of one follow back to back.
// Reset clears phase, carry and line count and loads line mode 1, 19 groups/line.
// A stall on the output holds the current character and stalls the input while the
// buffered run has more than its final character left or that final character is held.
module base64_stream_encoder_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  b64se_pkg::in_t                    in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output b64se_pkg::out_t                   out_data_o,
  input  logic                              cfg_we_i,
  input  logic [b64se_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [b64se_pkg::CfgDatW-1:0]     cfg_wdata_i
);

  logic            line_mode_q;
  logic [7:0]      groups_q;
  logic            accept;
  logic            free;
  b64se_pkg::run_t run;

  assign in_stall_o = !free;
  assign accept = in_valid_i && free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_mode_q <= b64se_pkg::LineModeReset;
      groups_q <= b64se_pkg::GroupsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        b64se_pkg::CfgLineMode:      line_mode_q <= cfg_wdata_i[0];
        b64se_pkg::CfgGroupsPerLine: groups_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  b64se_encode u_encode (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .in_data_i         (in_data_i),
    .line_mode_i       (line_mode_q),
    .groups_per_line_i (groups_q),
    .run_o             (run)
  );

  b64se_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && (run.cnt != '0)),
    .run_i       (run),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .free_o      (free)
  );

endmodule

// ----- src/b64se_checker.sv -----
module b64se_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input b64se_pkg::out_t               out_data_o
);

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

  a_end_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.message_end |-> out_data_o.last_of_run)
    else $error("message end outside run end");

  // a run keeps going until its final character
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_of_run |=> out_valid_o)
    else $error("run broke off early");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with nothing buffered");

  a_stall_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |-> !out_data_o.last_of_run)
    else $error("input stalled while run drains");

endmodule

bind base64_stream_encoder_unit b64se_checker u_b64se_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
